[rtl/multi_stack_shared_memory_core_assert.svh]
// assertion macros for the multi-stack shared memory core
// used by the controller; no other dependencies
`ifndef MULTI_STACK_SHARED_MEMORY_CORE_ASSERT_SVH
`define MULTI_STACK_SHARED_MEMORY_CORE_ASSERT_SVH

// same-cycle implication
`define MSSM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mssm assertion failed");

// next-cycle implication
`define MSSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mssm assertion failed");

`endif

[rtl/mssm_pkg.sv]
// shared types and constants for the multi-stack shared memory core
// no dependencies
package mssm_pkg;

   localparam int STORE_WORDS     = 128;
   localparam int MAX_STACK_COUNT = 16;
   localparam int ADDR_W          = $clog2(STORE_WORDS);
   localparam int PTR_W           = ADDR_W + 1;
   localparam int IDX_W           = 4;
   localparam int CNT_W           = 5;
   localparam int DATA_W          = 32;

   typedef logic [PTR_W-1:0] ptr_type;

   // words per stack for an even split, indexed by stack count
   localparam ptr_type SHARE_TABLE [0:MAX_STACK_COUNT] = '{
      PTR_W'(STORE_WORDS),      PTR_W'(STORE_WORDS / 1),  PTR_W'(STORE_WORDS / 2),
      PTR_W'(STORE_WORDS / 3),  PTR_W'(STORE_WORDS / 4),  PTR_W'(STORE_WORDS / 5),
      PTR_W'(STORE_WORDS / 6),  PTR_W'(STORE_WORDS / 7),  PTR_W'(STORE_WORDS / 8),
      PTR_W'(STORE_WORDS / 9),  PTR_W'(STORE_WORDS / 10), PTR_W'(STORE_WORDS / 11),
      PTR_W'(STORE_WORDS / 12), PTR_W'(STORE_WORDS / 13), PTR_W'(STORE_WORDS / 14),
      PTR_W'(STORE_WORDS / 15), PTR_W'(STORE_WORDS / 16)
   };

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADIDX = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_LSEARCH,
      S_HSEARCH,
      S_LCOPY,
      S_HCOPY,
      S_LFIX,
      S_HFIX,
      S_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic split;
      logic check;
      logic pop;
      logic push_here;
      logic ptr_dec;
      logic ptr_inc;
      logic ptr_hi;
      logic lo_start;
      logic hi_start;
      logic copy;
      logic fix_lo;
      logic fix_hi;
      logic emit_data;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic room;
      logic empty;
      logic out_of_use;
      logic ptr_zero;
      logic copy_done;
   } stat_type;

endpackage

[rtl/mssm_datapath.sv]
// datapath: word store, stack bounds, pointers and copy engine
// depends on mssm_pkg
module mssm_datapath import mssm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic                     req_operation,
   input  logic [IDX_W-1:0]         req_stack_index,
   input  logic signed [DATA_W-1:0] req_push_value,
   input  logic [CNT_W-1:0]         csr_num_stacks,
   output logic signed [DATA_W-1:0] rsp_pop_value
);

   logic [DATA_W-1:0] mem [STORE_WORDS];

   ptr_type           base_ff [MAX_STACK_COUNT];
   ptr_type           lim_ff  [MAX_STACK_COUNT];
   ptr_type           tp_ff   [MAX_STACK_COUNT];
   logic [CNT_W-1:0]  n_ff;
   logic              op_ff;
   logic [IDX_W-1:0]  i_ff;
   logic [DATA_W-1:0] val_ff;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  j_ff;
   ptr_type           tpi_ff, limi_ff, k_ff;
   logic              dir_ff;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic [IDX_W-1:0]  pidx;
   ptr_type           base_p, lim_p, tp_p;
   logic [CNT_W-1:0]  nsat;
   ptr_type           share;
   logic              more;
   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [DATA_W-1:0] wdata;
   ptr_type           tp_m1, limi_m1, k_m1, k_p1;

   assign pidx   = ptr_ff[IDX_W-1:0];
   assign base_p = base_ff[pidx];
   assign lim_p  = lim_ff[pidx];
   assign tp_p   = tp_ff[pidx];
   assign tp_m1  = tp_p - PTR_W'(1);
   assign limi_m1 = limi_ff - PTR_W'(1);
   assign k_m1   = k_ff - PTR_W'(1);
   assign k_p1   = k_ff + PTR_W'(1);

   assign nsat  = (csr_num_stacks == '0) ? CNT_W'(1) :
                  (csr_num_stacks > CNT_W'(MAX_STACK_COUNT)) ? CNT_W'(MAX_STACK_COUNT) :
                  csr_num_stacks;
   assign share = SHARE_TABLE[nsat];

   assign more = dir_ff ? (k_ff > tpi_ff) : (k_ff < limi_ff);

   always_comb begin
      stat.is_pop     = op_ff;
      stat.room       = tp_p < lim_p;
      stat.empty      = tp_p == base_p;
      stat.out_of_use = ptr_ff >= n_ff;
      stat.ptr_zero   = ptr_ff == '0;
      stat.copy_done  = !more && !pend_ff;
   end

   // store port selection
   always_comb begin
      we    = 1'b0;
      waddr = pend_addr_ff;
      wdata = rd_data_ff;
      if (pend_ff) begin
         we = 1'b1;
      end else if (cmd.push_here) begin
         we    = 1'b1;
         waddr = tp_p[ADDR_W-1:0];
         wdata = val_ff;
      end else if (cmd.fix_lo) begin
         we    = 1'b1;
         waddr = limi_m1[ADDR_W-1:0];
         wdata = val_ff;
      end else if (cmd.fix_hi) begin
         we    = 1'b1;
         waddr = tpi_ff[ADDR_W-1:0];
         wdata = val_ff;
      end
      re    = 1'b0;
      raddr = tp_m1[ADDR_W-1:0];
      if (cmd.pop) begin
         re = 1'b1;
      end else if (cmd.copy && more) begin
         re    = 1'b1;
         raddr = dir_ff ? k_m1[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rsp_pop_value = cmd.emit_data ? rd_data_ff : '0;

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = {1'b0, req_stack_index};
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - CNT_W'(1);
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CNT_W'(1);
      end else if (cmd.ptr_hi) begin
         ptr_in = {1'b0, i_ff} + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         op_ff  <= req_operation;
         i_ff   <= req_stack_index;
         val_ff <= req_push_value;
      end
      if (cmd.check) begin
         tpi_ff  <= tp_p;
         limi_ff <= lim_p;
      end
      if (cmd.lo_start) begin
         j_ff   <= pidx;
         k_ff   <= lim_p;
         dir_ff <= 1'b0;
      end else if (cmd.hi_start) begin
         j_ff   <= pidx;
         k_ff   <= tp_p;
         dir_ff <= 1'b1;
      end else if (cmd.copy && more) begin
         k_ff <= dir_ff ? k_m1 : k_p1;
      end
      if (cmd.copy && more) begin
         pend_addr_ff <= dir_ff ? k_ff[ADDR_W-1:0] : k_m1[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.copy && more;
      end
   end

   // stack bounds
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= CNT_W'(1);
         for (int s = 0; s < MAX_STACK_COUNT; s++) begin
            base_ff[s] <= (s == 0) ? '0 : PTR_W'(STORE_WORDS);
            tp_ff[s]   <= (s == 0) ? '0 : PTR_W'(STORE_WORDS);
            lim_ff[s]  <= PTR_W'(STORE_WORDS);
         end
      end else if (cmd.split) begin
         n_ff <= nsat;
         for (int s = 0; s < MAX_STACK_COUNT; s++) begin
            if (CNT_W'(s) < nsat) begin
               base_ff[s] <= PTR_W'(share * PTR_W'(s));
               tp_ff[s]   <= PTR_W'(share * PTR_W'(s));
               lim_ff[s]  <= (CNT_W'(s + 1) < nsat) ? PTR_W'(share * PTR_W'(s + 1)) :
                             PTR_W'(STORE_WORDS);
            end else begin
               base_ff[s] <= PTR_W'(STORE_WORDS);
               tp_ff[s]   <= PTR_W'(STORE_WORDS);
               lim_ff[s]  <= PTR_W'(STORE_WORDS);
            end
         end
      end else begin
         for (int s = 0; s < MAX_STACK_COUNT; s++) begin
            if (cmd.pop && IDX_W'(s) == i_ff) begin
               tp_ff[s] <= tp_ff[s] - PTR_W'(1);
            end
            if (cmd.push_here && IDX_W'(s) == i_ff) begin
               tp_ff[s] <= tp_ff[s] + PTR_W'(1);
            end
            if (cmd.fix_lo) begin
               if (IDX_W'(s) > j_ff && IDX_W'(s) <= i_ff) begin
                  base_ff[s] <= base_ff[s] - PTR_W'(1);
               end
               if (IDX_W'(s) > j_ff && IDX_W'(s) < i_ff) begin
                  tp_ff[s] <= tp_ff[s] - PTR_W'(1);
               end
               if (IDX_W'(s) >= j_ff && IDX_W'(s) < i_ff) begin
                  lim_ff[s] <= lim_ff[s] - PTR_W'(1);
               end
            end
            if (cmd.fix_hi) begin
               if (IDX_W'(s) > i_ff && IDX_W'(s) <= j_ff) begin
                  base_ff[s] <= base_ff[s] + PTR_W'(1);
               end
               if (IDX_W'(s) >= i_ff && IDX_W'(s) <= j_ff) begin
                  tp_ff[s] <= tp_ff[s] + PTR_W'(1);
               end
               if (IDX_W'(s) >= i_ff && IDX_W'(s) < j_ff) begin
                  lim_ff[s] <= lim_ff[s] + PTR_W'(1);
               end
            end
         end
      end
   end

endmodule

[rtl/mssm_controller.sv]
// controller state machine: sequences checks, searches, copies and results
// depends on mssm_pkg and the assertion macro header
`include "multi_stack_shared_memory_core_assert.svh"

module mssm_controller import mssm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   output logic       busy,
   input  logic       csr_valid,
   output logic       csr_ready,
   output logic       rsp_strobe,
   output logic [1:0] rsp_status,
   input  stat_type   stat,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   status_type st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      cmd        = '0;
      busy       = state_ff != S_IDLE;
      csr_ready  = (state_ff == S_IDLE) && !req_start;
      rsp_strobe = 1'b0;
      rsp_status = st_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.split = csr_valid && csr_ready;
            if (req_start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_RESP;
            if (stat.out_of_use) begin
               st_in = ST_BADIDX;
            end else if (stat.is_pop) begin
               if (stat.empty) begin
                  st_in = ST_EMPTY;
               end else begin
                  cmd.pop = 1'b1;
                  st_in   = ST_OK;
               end
            end else if (stat.room) begin
               cmd.push_here = 1'b1;
               st_in         = ST_OK;
            end else if (stat.ptr_zero) begin
               cmd.ptr_hi = 1'b1;
               state_in   = S_HSEARCH;
            end else begin
               cmd.ptr_dec = 1'b1;
               state_in    = S_LSEARCH;
            end
         end
         S_LSEARCH: begin
            if (stat.room) begin
               cmd.lo_start = 1'b1;
               state_in     = S_LCOPY;
            end else if (stat.ptr_zero) begin
               cmd.ptr_hi = 1'b1;
               state_in   = S_HSEARCH;
            end else begin
               cmd.ptr_dec = 1'b1;
            end
         end
         S_HSEARCH: begin
            if (stat.out_of_use) begin
               st_in    = ST_FULL;
               state_in = S_RESP;
            end else if (stat.room) begin
               cmd.hi_start = 1'b1;
               state_in     = S_HCOPY;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_LCOPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_done) begin
               state_in = S_LFIX;
            end
         end
         S_HCOPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_done) begin
               state_in = S_HFIX;
            end
         end
         S_LFIX: begin
            cmd.fix_lo = 1'b1;
            st_in      = ST_OK;
            state_in   = S_RESP;
         end
         S_HFIX: begin
            cmd.fix_hi = 1'b1;
            st_in      = ST_OK;
            state_in   = S_RESP;
         end
         S_RESP: begin
            rsp_strobe    = 1'b1;
            cmd.emit_data = stat.is_pop && (st_ff == ST_OK);
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `MSSM_ASSERT_NXT(a_accept_busy, clock, reset, req_start && !busy, busy)
   `MSSM_ASSERT_NOW(a_resp_busy, clock, reset, rsp_strobe, busy && !csr_ready)
   `MSSM_ASSERT_NXT(a_resp_single, clock, reset, rsp_strobe, !rsp_strobe && !busy)
   `MSSM_ASSERT_NXT(a_cfg_no_resp, clock, reset, csr_valid && csr_ready, !rsp_strobe)

endmodule

[rtl/multi_stack_shared_memory_core.sv]
// Several stacks sharing one word store. A push into a stack with room, a pop, or a
// rejected item passes a check state and then a result state that puts out its
// result strobe; busy drops the cycle after. A push to a full stack first searches
// for a stack with room and then moves words one at a time, since the store has a
// single read and a single write port; when no stack has room it is rejected as full.
// A num_stacks write re-splits the store. Each result appears for exactly one cycle on
// rsp_strobe and cannot be held off; csr writes are taken only while idle. There is no
// clearing pass after reset.
// top level: joins mssm_controller and mssm_datapath, depends on mssm_pkg
module multi_stack_shared_memory_core import mssm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   output logic                     busy,
   input  logic                     req_operation,
   input  logic [IDX_W-1:0]         req_stack_index,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_pop_value,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CNT_W-1:0]         csr_num_stacks
);

   cmd_type  cmd;
   stat_type stat;

   mssm_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .busy       (busy),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .stat       (stat),
      .cmd        (cmd)
   );

   mssm_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_stack_index (req_stack_index),
      .req_push_value  (req_push_value),
      .csr_num_stacks  (csr_num_stacks),
      .rsp_pop_value   (rsp_pop_value)
   );

endmodule
